/* rtl/rts_pkg.sv */
// Package for the I2C register transfer sequencer: item, state and result types,
// event and phase codes, and the transfer length limit.
// No dependencies.
package rts_pkg;

  localparam int MAX_BYTES  = 4;
  localparam int WORD_BYTES = 4;
  // Count width: holds MAX_BYTES and never narrower than the byte_count field.
  localparam int CNT_W = ($clog2(MAX_BYTES + 1) > 3) ? $clog2(MAX_BYTES + 1) : 3;

  typedef enum logic [1:0] {
    EV_START = 2'd0,
    EV_ACK   = 2'd1,
    EV_RX    = 2'd2,
    EV_STOP  = 2'd3
  } kind_t;

  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_SEND_REG = 6'b000010,
    PH_RESTART  = 6'b000100,
    PH_RECEIVE  = 6'b001000,
    PH_WRITE    = 6'b010000,
    PH_WAITSTOP = 6'b100000
  } phase_t;

  typedef logic [WORD_BYTES-1:0][7:0] word_bytes_t;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  target_addr;
    logic        is_read;
    logic [31:0] write_word;
    logic [2:0]  byte_count;
    logic [7:0]  target_reg;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        cmd_start;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        cmd_ack;
    logic        cmd_nack;
    logic        cmd_stop;
    logic [31:0] data_word;
    logic        done_res;
    logic        error;
    logic        ready_res;
  } out_item_t;

  typedef struct packed {
    phase_t           phase;
    logic             read_mode;
    logic [6:0]       device_addr;
    logic [7:0]       register_addr;
    logic [31:0]      word_buffer;
    logic [CNT_W-1:0] bytes_left;
  } seq_state_t;

endpackage

/* rtl/rts_if.sv */
// Valid/ready channel interfaces for the sequencer's event and result items.
// Depends on nothing; fields follow the widths of the item types in rts_pkg.
interface rts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [6:0]  target_addr;
  logic        is_read;
  logic [31:0] write_word;
  logic [2:0]  byte_count;
  logic [7:0]  target_reg;
  logic [7:0]  rx_byte;

  modport source (output valid, kind, target_addr, is_read, write_word, byte_count,
                  target_reg, rx_byte, input ready);
  modport sink (input valid, kind, target_addr, is_read, write_word, byte_count,
                target_reg, rx_byte, output ready);
endinterface

interface rts_out_if;
  logic        valid;
  logic        ready;
  logic        cmd_start;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        cmd_ack;
  logic        cmd_nack;
  logic        cmd_stop;
  logic [31:0] data_word;
  logic        done_res;
  logic        error;
  logic        ready_res;

  modport source (output valid, cmd_start, tx_valid, tx_byte, cmd_ack, cmd_nack, cmd_stop,
                  data_word, done_res, error, ready_res, input ready);
  modport sink (input valid, cmd_start, tx_valid, tx_byte, cmd_ack, cmd_nack, cmd_stop,
                data_word, done_res, error, ready_res, output ready);
endinterface

/* rtl/i2c_register_transfer_sequencer.sv */
// I2C register transfer sequencer: takes event items (start, ack seen, byte received,
// stop done) at one item per clock while the result side is not stalled, and returns
// exactly one command/status result item for each. An accepted item is registered in
// the input register, then the combinational step logic updates the transfer state and
// loads the result register. The input side keeps taking items while a result waits,
// until both registers are full.
// Depends on rts_pkg, rts_if and rts_step.
module i2c_register_transfer_sequencer
  import rts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  rts_in_if.sink    in_ch,
  rts_out_if.source out_ch
);

  logic       in_held;
  in_item_t   in_item;
  logic       out_held;
  out_item_t  out_item;
  logic       step_fire;
  seq_state_t st;
  seq_state_t st_next;
  out_item_t  step_res;
  in_item_t   in_port_item;

  assign in_port_item = '{
    kind:        kind_t'(in_ch.kind),
    target_addr: in_ch.target_addr,
    is_read:     in_ch.is_read,
    write_word:  in_ch.write_word,
    byte_count:  in_ch.byte_count,
    target_reg:  in_ch.target_reg,
    rx_byte:     in_ch.rx_byte
  };

  assign step_fire   = in_held && (!out_held || out_ch.ready);
  assign in_ch.ready = !in_held || step_fire;

  rts_step u_step (
    .st      (st),
    .item    (in_item),
    .st_next (st_next),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_held <= 1'b1;
    end else if (step_fire) begin
      in_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item <= in_port_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_IDLE, default: '0};
    end else if (step_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_held <= 1'b0;
    end else if (step_fire) begin
      out_held <= 1'b1;
    end else if (out_ch.ready) begin
      out_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_item <= step_res;
    end
  end

  assign out_ch.valid     = out_held;
  assign out_ch.cmd_start = out_item.cmd_start;
  assign out_ch.tx_valid  = out_item.tx_valid;
  assign out_ch.tx_byte   = out_item.tx_byte;
  assign out_ch.cmd_ack   = out_item.cmd_ack;
  assign out_ch.cmd_nack  = out_item.cmd_nack;
  assign out_ch.cmd_stop  = out_item.cmd_stop;
  assign out_ch.data_word = out_item.data_word;
  assign out_ch.done_res  = out_item.done_res;
  assign out_ch.error     = out_item.error;
  assign out_ch.ready_res = out_item.ready_res;

`ifndef SYNTHESIS
  // A rejected event leaves the transfer phase untouched.
  a_error_keeps_phase: assert property (@(posedge clk) disable iff (rst)
    step_fire && step_res.error |=> st.phase == $past(st.phase))
    else $error("phase changed on an illegal event");

  // Completion always lands the block back in idle.
  a_done_is_idle: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.done_res |-> out_ch.ready_res)
    else $error("done reported while not idle");

  // An illegal event issues no bus command.
  a_error_no_cmd: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.error |-> !(out_ch.tx_valid || out_ch.cmd_start ||
      out_ch.cmd_ack || out_ch.cmd_nack || out_ch.cmd_stop || out_ch.done_res))
    else $error("command issued together with error");

  // A held result is not overwritten while the sink stalls.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_held && !out_ch.ready |-> !step_fire)
    else $error("result register overwritten while stalled");
`endif

endmodule

/* rtl/rts_step.sv */
// Next-state and result logic for one event of the register transfer sequencer.
// Depends on rts_pkg.
module rts_step
  import rts_pkg::*;
(
  input  seq_state_t st,
  input  in_item_t   item,
  output seq_state_t st_next,
  output out_item_t  res
);

  logic [CNT_W-1:0] count_sat;
  logic [CNT_W-1:0] left_dec;
  logic             left_in_word;
  word_bytes_t      word_view;
  word_bytes_t      word_merged;

  always_comb begin
    if (int'(item.byte_count) > MAX_BYTES) begin
      count_sat = CNT_W'(MAX_BYTES);
    end else if (item.byte_count == 3'd0) begin
      count_sat = CNT_W'(1);
    end else begin
      count_sat = CNT_W'(item.byte_count);
    end
  end

  // Byte position of the next data byte, most significant first.
  assign left_dec     = (st.bytes_left != '0) ? st.bytes_left - CNT_W'(1) : '0;
  assign left_in_word = int'(left_dec) < WORD_BYTES;
  assign word_view    = word_bytes_t'(st.word_buffer);

  always_comb begin
    word_merged = word_view;
    if (left_in_word) begin
      word_merged[left_dec[1:0]] = item.rx_byte;
    end
  end

  always_comb begin
    st_next = st;
    res     = '0;
    unique case (item.kind)
      EV_START: begin
        if (st.phase != PH_IDLE) begin
          res.error = 1'b1;
        end else begin
          st_next.device_addr   = item.target_addr;
          st_next.read_mode     = item.is_read;
          st_next.word_buffer   = item.write_word;
          st_next.bytes_left    = count_sat;
          st_next.register_addr = item.target_reg;
          st_next.phase         = PH_SEND_REG;
          res.cmd_start         = 1'b1;
          res.tx_valid          = 1'b1;
          res.tx_byte           = {item.target_addr, 1'b0};
        end
      end
      EV_ACK: begin
        unique case (st.phase) inside
          PH_SEND_REG: begin
            res.tx_valid  = 1'b1;
            res.tx_byte   = st.register_addr;
            st_next.phase = st.read_mode ? PH_RESTART : PH_WRITE;
          end
          PH_RESTART: begin
            res.cmd_start = 1'b1;
            res.tx_valid  = 1'b1;
            res.tx_byte   = {st.device_addr, 1'b1};
            st_next.phase = PH_RECEIVE;
          end
          PH_WRITE: begin
            st_next.bytes_left = left_dec;
            res.tx_valid       = 1'b1;
            res.tx_byte        = left_in_word ? word_view[left_dec[1:0]] : 8'h00;
            if (left_dec == '0) begin
              res.cmd_stop  = 1'b1;
              st_next.phase = PH_WAITSTOP;
            end
          end
          PH_RECEIVE, PH_WAITSTOP: begin
          end
          default: begin
            res.error = 1'b1;
          end
        endcase
      end
      EV_RX: begin
        unique case (st.phase) inside
          PH_RECEIVE: begin
            st_next.bytes_left  = left_dec;
            st_next.word_buffer = 32'(word_merged);
            if (left_dec != '0) begin
              res.cmd_ack = 1'b1;
            end else begin
              res.cmd_nack  = 1'b1;
              res.cmd_stop  = 1'b1;
              st_next.phase = PH_WAITSTOP;
            end
          end
          PH_SEND_REG, PH_RESTART: begin
          end
          default: begin
            res.error = 1'b1;
          end
        endcase
      end
      EV_STOP: begin
        if (st.phase == PH_WRITE || st.phase == PH_WAITSTOP) begin
          st_next.phase = PH_IDLE;
          res.done_res  = 1'b1;
        end else begin
          res.error = 1'b1;
        end
      end
      default: begin
        res.error = 1'b1;
      end
    endcase
    res.data_word = st_next.word_buffer;
    res.ready_res = (st_next.phase == PH_IDLE);
  end

endmodule
